@@ src/prrs_pkg.sv @@
// Shared types, constants and helpers for the priority ready-queue scheduler.
`default_nettype none
package prrs_pkg;
    localparam int NUM_LEVELS = 32;
    localparam int NUM_TASKS  = 16;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int TOP_W      = LVL_W + 1;
    localparam int TID_W      = $clog2(NUM_TASKS);
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [7:0] SLICE_RESET = 8'd10;
    localparam logic [7:0] DEPTH_MAX   = 8'd255;

    typedef enum logic [KIND_W-1:0] {
        K_ADD     = 3'd0,
        K_REMOVE  = 3'd1,
        K_SWITCH  = 3'd2,
        K_TICK    = 3'd3,
        K_CHECK   = 3'd4,
        K_SUSPEND = 3'd5,
        K_RESUME  = 3'd6,
        K_BLOCK   = 3'd7
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_LEN = 2'd0,
        CFG_SLICE_EN  = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ,
        S_SEL,
        S_UNL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic simple;
        logic enq;
        logic enq_cur;
        logic sel;
        logic unl;
        logic unl_sel;
        logic take;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  add_ok;
        logic  rem_ok;
        logic  suspended;
        logic  running;
        logic  top_none;
    } t_status;

    function automatic logic [TOP_W-1:0] top_level(input logic [NUM_LEVELS-1:0] bm);
        logic [TOP_W-1:0] r;
        r = TOP_W'(NUM_LEVELS);
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (bm[i]) begin
                r = TOP_W'(i);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ src/prrs_in_if.sv @@
// Input channel: scheduler request transaction.
`default_nettype none
interface prrs_in_if;
    logic                         valid;
    logic                         ready;
    logic [prrs_pkg::KIND_W-1:0]  kind;
    logic [prrs_pkg::TID_W-1:0]   task_id;
    logic [prrs_pkg::LVL_W-1:0]   task_priority;
    modport source (output valid, kind, task_id, task_priority, input ready);
    modport sink   (input valid, kind, task_id, task_priority, output ready);
endinterface
`default_nettype wire

@@ src/prrs_out_if.sv @@
// Output channel: scheduler result transaction.
`default_nettype none
interface prrs_out_if;
    logic                        valid;
    logic                        ready;
    logic [prrs_pkg::TID_W-1:0]  running_task;
    logic                        running_valid;
    logic                        switched;
    logic                        yield_flag;
    logic                        yield_now;
    logic [prrs_pkg::TOP_W-1:0]  top_ready_level;
    modport source (output valid, running_task, running_valid, switched, yield_flag,
                    yield_now, top_ready_level, input ready);
    modport sink   (input valid, running_task, running_valid, switched, yield_flag,
                    yield_now, top_ready_level, output ready);
endinterface
`default_nettype wire

@@ src/prrs_ctrl.sv @@
// Controller state machine sequencing queue operations per transaction.
`default_nettype none
module prrs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire prrs_pkg::t_status i_status,
    output prrs_pkg::t_cmd         o_cmd
);
    import prrs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load;

    assign load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_status.kind)
                    K_ADD:    n_state = i_status.add_ok ? S_ENQ : S_OUT;
                    K_REMOVE: n_state = i_status.rem_ok ? S_UNL : S_OUT;
                    K_SWITCH: begin
                        if (i_status.suspended)    n_state = S_OUT;
                        else if (i_status.running) n_state = S_ENQ;
                        else                       n_state = S_SEL;
                    end
                    default:  n_state = S_OUT;
                endcase
            end
            S_ENQ:   n_state = (i_status.kind == K_SWITCH) ? S_SEL : S_OUT;
            S_SEL:   n_state = i_status.top_none ? S_OUT : S_UNL;
            S_UNL:   n_state = S_OUT;
            S_OUT: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = (r_state == S_IDLE);
        o_out_valid    = r_out_valid;
        n_out_valid    = load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.simple   = (r_state == S_DECODE);
        o_cmd.enq      = (r_state == S_ENQ);
        o_cmd.enq_cur  = (i_status.kind == K_SWITCH);
        o_cmd.sel      = (r_state == S_SEL);
        o_cmd.unl      = (r_state == S_UNL);
        o_cmd.unl_sel  = (i_status.kind == K_SWITCH);
        o_cmd.take     = (r_state == S_UNL) && (i_status.kind == K_SWITCH);
        o_cmd.load_out = load;
    end
endmodule
`default_nettype wire

@@ src/prrs_datapath.sv @@
// Datapath: ready queues, bitmap, current task, slice and suspend state.
`default_nettype none
module prrs_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire prrs_pkg::t_cmd                  i_cmd,
    output prrs_pkg::t_status                    o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [prrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [prrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [prrs_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [prrs_pkg::TID_W-1:0]      i_task_id,
    input  wire logic [prrs_pkg::LVL_W-1:0]      i_task_priority,
    output logic [prrs_pkg::TID_W-1:0]           o_running_task,
    output logic                                 o_running_valid,
    output logic                                 o_switched,
    output logic                                 o_yield_flag,
    output logic                                 o_yield_now,
    output logic [prrs_pkg::TOP_W-1:0]           o_top_ready_level
);
    import prrs_pkg::*;

    logic [7:0]            r_slice_len;
    logic                  r_slice_en;
    t_kind                 r_kind;
    logic [TID_W-1:0]      r_tid;
    logic [LVL_W-1:0]      r_prio;
    logic [NUM_LEVELS-1:0] r_bitmap;
    logic [TID_W-1:0]      r_head [NUM_LEVELS];
    logic [TID_W-1:0]      r_tail [NUM_LEVELS];
    logic [TID_W-1:0]      r_next [NUM_TASKS];
    logic [TID_W-1:0]      r_prev [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_queued;
    logic [LVL_W-1:0]      r_qlvl [NUM_TASKS];
    logic [TID_W-1:0]      r_cur_task;
    logic [LVL_W-1:0]      r_cur_lvl;
    logic                  r_cur_valid;
    logic                  r_cur_run;
    logic [7:0]            r_slice_left;
    logic [7:0]            r_depth;
    logic                  r_yield;
    logic                  r_sw;
    logic                  r_ynow;
    logic [TID_W-1:0]      r_nxt;
    logic [LVL_W-1:0]      r_top;
    logic                  r_came_back;

    logic [TOP_W-1:0] top;
    logic [TID_W-1:0] enq_t, unl_t, unl_nx, unl_pv;
    logic [LVL_W-1:0] enq_l, unl_l;
    logic             at_head, at_tail, running, enq_has;
    logic [7:0]       reload, tick_dec;

    assign top     = top_level(r_bitmap);
    assign running = r_cur_valid && r_cur_run;
    assign reload  = (r_slice_len == 8'd0) ? 8'd1 : r_slice_len;
    assign tick_dec = (r_slice_left != 8'd0) ? r_slice_left - 8'd1 : 8'd0;
    assign enq_t   = i_cmd.enq_cur ? r_cur_task : r_tid;
    assign enq_l   = i_cmd.enq_cur ? r_cur_lvl : r_prio;
    assign enq_has = r_bitmap[enq_l];
    assign unl_t   = i_cmd.unl_sel ? r_nxt : r_tid;
    assign unl_l   = r_qlvl[unl_t];
    assign unl_nx  = r_next[unl_t];
    assign unl_pv  = r_prev[unl_t];
    assign at_head = (r_head[unl_l] == unl_t);
    assign at_tail = (r_tail[unl_l] == unl_t);

    assign o_status.kind      = r_kind;
    assign o_status.add_ok    = !r_queued[r_tid] && !(running && r_cur_task == r_tid);
    assign o_status.rem_ok    = r_queued[r_tid];
    assign o_status.suspended = (r_depth != 8'd0);
    assign o_status.running   = running;
    assign o_status.top_none  = (top == TOP_W'(NUM_LEVELS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tid  <= i_task_id;
            r_prio <= i_task_priority;
        end
        if (i_cmd.enq) begin
            if (enq_has) begin
                r_next[r_tail[enq_l]] <= enq_t;
                r_prev[enq_t]         <= r_tail[enq_l];
            end else begin
                r_head[enq_l] <= enq_t;
                r_prev[enq_t] <= enq_t;
            end
            r_next[enq_t] <= enq_t;
            r_tail[enq_l] <= enq_t;
            r_qlvl[enq_t] <= enq_l;
        end
        if (i_cmd.sel) begin
            r_nxt       <= r_head[top[LVL_W-1:0]];
            r_top       <= top[LVL_W-1:0];
            r_came_back <= running && (r_head[top[LVL_W-1:0]] == r_cur_task);
        end
        if (i_cmd.unl && !(at_head && at_tail)) begin
            if (at_head) begin
                r_head[unl_l] <= unl_nx;
            end else if (at_tail) begin
                r_tail[unl_l] <= unl_pv;
            end else begin
                r_next[unl_pv] <= unl_nx;
                r_prev[unl_nx] <= unl_pv;
            end
        end
        if (i_cmd.load_out) begin
            o_running_task    <= r_cur_valid ? r_cur_task : '0;
            o_running_valid   <= r_cur_valid;
            o_switched        <= r_sw;
            o_yield_flag      <= r_yield;
            o_yield_now       <= r_ynow;
            o_top_ready_level <= top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len  <= SLICE_RESET;
            r_slice_en   <= 1'b1;
            r_kind       <= K_ADD;
            r_bitmap     <= '0;
            r_queued     <= '0;
            r_cur_task   <= '0;
            r_cur_lvl    <= '0;
            r_cur_valid  <= 1'b0;
            r_cur_run    <= 1'b0;
            r_slice_left <= '0;
            r_depth      <= '0;
            r_yield      <= 1'b0;
            r_sw         <= 1'b0;
            r_ynow       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLICE_LEN) r_slice_len <= i_cfg_data;
                if (i_cfg_idx == CFG_SLICE_EN)  r_slice_en  <= i_cfg_data[0];
            end
            if (i_cmd.accept) begin
                r_kind <= t_kind'(i_kind);
                r_sw   <= 1'b0;
                r_ynow <= 1'b0;
            end
            if (i_cmd.simple) begin
                case (r_kind)
                    K_SWITCH: begin
                        if (r_depth != 8'd0) r_yield <= 1'b1;
                    end
                    K_TICK: begin
                        if (r_slice_en && r_depth == 8'd0 && running) begin
                            if (tick_dec == 8'd0) begin
                                if (r_bitmap[r_cur_lvl]) begin
                                    r_yield      <= 1'b1;
                                    r_slice_left <= tick_dec;
                                end else begin
                                    r_slice_left <= reload;
                                end
                            end else begin
                                r_slice_left <= tick_dec;
                            end
                        end
                    end
                    K_CHECK: begin
                        if (top != TOP_W'(NUM_LEVELS) && r_cur_valid &&
                            top < {1'b0, r_cur_lvl}) r_yield <= 1'b1;
                    end
                    K_SUSPEND: begin
                        if (r_depth != DEPTH_MAX) r_depth <= r_depth + 8'd1;
                    end
                    K_RESUME: begin
                        if (r_depth != 8'd0) begin
                            r_depth <= r_depth - 8'd1;
                            if (r_depth == 8'd1 && r_yield) r_ynow <= 1'b1;
                        end
                    end
                    K_BLOCK: begin
                        if (running) r_cur_run <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.enq) begin
                r_bitmap[enq_l] <= 1'b1;
                r_queued[enq_t] <= 1'b1;
            end
            if (i_cmd.unl) begin
                if (at_head && at_tail) r_bitmap[unl_l] <= 1'b0;
                r_queued[unl_t] <= 1'b0;
            end
            if (i_cmd.take) begin
                r_cur_task  <= r_nxt;
                r_cur_lvl   <= r_top;
                r_cur_valid <= 1'b1;
                r_cur_run   <= 1'b1;
                r_yield     <= 1'b0;
                if (!r_came_back) begin
                    r_slice_left <= reload;
                    r_sw         <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/priority_round_robin_task_scheduler_core.sv @@
// Top level of the priority ready-queue task scheduler.
// Channel | Dir | Fields
// i_in    | in  | kind, task_id, task_priority
// o_out   | out | running_task, running_valid, switched, yield_flag, yield_now,
//         |     | top_ready_level
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// One transaction at a time, set by the controller walking the queue tables.
// Steps per transaction: decode, then result for tick, check, suspend, resume,
// block and an ignored add or remove; add enqueues and remove unlinks before
// the result; switch may requeue, select and unlink first. Reset is synchronous;
// no clearing pass. A stalled result holds the output register; the next request
// is taken before it drains.
`default_nettype none
module priority_round_robin_task_scheduler_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [prrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [prrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    prrs_in_if.sink                              i_in,
    prrs_out_if.source                           o_out
);
    import prrs_pkg::*;

    t_cmd    cmd;
    t_status status;

    prrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    prrs_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_in.kind),
        .i_task_id         (i_in.task_id),
        .i_task_priority   (i_in.task_priority),
        .o_running_task    (o_out.running_task),
        .o_running_valid   (o_out.running_valid),
        .o_switched        (o_out.switched),
        .o_yield_flag      (o_out.yield_flag),
        .o_yield_now       (o_out.yield_now),
        .o_top_ready_level (o_out.top_ready_level)
    );

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request accepted while busy");
    a_switch_needs_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.switched |-> o_out.running_valid)
        else $error("switch reported with no current task");
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.top_ready_level <= 6'(NUM_LEVELS))
        else $error("top ready level out of range");
`endif
endmodule
`default_nettype wire
